FILE: hdl/lsbr_pkg.sv
// lsbr_pkg: shared types, widths and command codes of the lsb-first bit field reader
// used by every file of the block but lsbr_if; depends on nothing
`default_nettype none

package lsbr_pkg;

    // fixed field widths
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned IDX_W    = 10;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned POS_W    = 14;
    // position plus a count, before clamping
    localparam int unsigned POSX_W   = POS_W + 1;
    // byte address derived from a wide position
    localparam int unsigned BADDR_W  = POSX_W - 3;

    // window of bytes gathered for one multi-bit read
    localparam int unsigned READ_BYTES = 9;
    localparam int unsigned ACC_W      = READ_BYTES * BYTE_W;
    localparam int unsigned FETCH_W    = 4;
    localparam int unsigned MAX_READ   = 64;

    // varuint32: up to five groups of seven bits
    localparam int unsigned VAR_GROUPS = 5;
    localparam int unsigned VAR_W      = VAR_GROUPS * 7;
    localparam int unsigned ITER_W     = 3;

    localparam int unsigned DEF_STORE_BYTES = 1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD     = 3'd0,
        CMD_REWIND   = 3'd1,
        CMD_READ_U   = 3'd2,
        CMD_READ_S   = 3'd3,
        CMD_ADVANCE  = 3'd4,
        CMD_READ_BIT = 3'd5,
        CMD_READ_VAR = 3'd6,
        CMD_NOP      = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_VAR,
        S_CALC,
        S_DONE
    } t_state;

    // input word
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [COUNT_W-1:0] count;
        logic [IDX_W-1:0]   byte_index;
        logic [BYTE_W-1:0]  byte_value;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               overflow;
        logic [POS_W-1:0]   position;
    } t_res_word;

    // store write request
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } t_wr_req;

    // store read request; blank marks a byte past the rounded-up stream end
    typedef struct packed {
        logic               re;
        logic [BADDR_W-1:0] addr;
        logic               blank;
    } t_rd_req;

    // store read response, registered: it arrives in the cycle after the request
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_rd_rsp;

endpackage

`default_nettype wire

FILE: hdl/lsbr_if.sv
// lsbr_if: valid/ready channel carrying one word of a given type
// payload types come from lsbr_pkg at the point of instantiation
`default_nettype none

interface lsbr_if #(
    parameter type t_word = logic
);
    logic  valid;
    logic  ready;
    t_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/lsbr_store.sv
// lsbr_store: byte store, one write port and one read port with registered data
// depends on lsbr_pkg for the request and response structs
`default_nettype none

module lsbr_store #(
    parameter int unsigned STORE_BYTES = lsbr_pkg::DEF_STORE_BYTES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lsbr_pkg::t_wr_req i_wr,
    input  wire lsbr_pkg::t_rd_req i_rd,
    output lsbr_pkg::t_rd_rsp      o_rd
);
    import lsbr_pkg::*;

    localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    logic [BYTE_W-1:0] mem [STORE_BYTES];
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_rd_valid;
    logic              r_rd_zero;
    logic              wr_in_range;
    logic              rd_in_range;

    // addresses past the store are dropped on write and read as zero
    assign wr_in_range = (32'(i_wr.addr) < STORE_BYTES);
    assign rd_in_range = (32'(i_rd.addr) < STORE_BYTES);

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we && wr_in_range) begin
            mem[AW'(i_wr.addr)] <= i_wr.data;
        end
    end

    // read port, data registered
    always_ff @(posedge i_clk) begin
        if (i_rd.re && rd_in_range) begin
            r_rd_data <= mem[AW'(i_rd.addr)];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_zero <= i_rd.blank || !rd_in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_rd.re;
        end
    end

    assign o_rd.valid = r_rd_valid;
    assign o_rd.data  = r_rd_zero ? '0 : r_rd_data;

endmodule

`default_nettype wire

FILE: hdl/lsbr_out_reg.sv
// lsbr_out_reg: one-word output register between the engine and the result channel
// depends on lsbr_pkg and lsbr_if
`default_nettype none

module lsbr_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire lsbr_pkg::t_res_word i_word,
    output logic                     o_ready,
    lsbr_if.source                   o_res
);
    import lsbr_pkg::*;

    logic      r_full;
    t_res_word r_word;

    // room when empty or when the held word leaves this cycle
    assign o_ready = !r_full || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (o_ready) begin
            r_full <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

    assign o_res.valid   = r_full;
    assign o_res.payload = r_word;

endmodule

`default_nettype wire

FILE: hdl/lsbr_engine.sv
// lsbr_engine: command sequencer; keeps position, overrun flag and stream length,
// gathers bytes from the store and forms results; depends on lsbr_pkg and lsbr_if
`default_nettype none

module lsbr_engine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [13:0]         i_cfg_wdata,
    lsbr_if.sink                     i_cmd,
    output lsbr_pkg::t_wr_req        o_wr,
    output lsbr_pkg::t_rd_req        o_rd,
    input  wire lsbr_pkg::t_rd_rsp   i_rd,
    output logic                     o_valid,
    output lsbr_pkg::t_res_word      o_word,
    input  wire logic                i_ready
);
    import lsbr_pkg::*;

    // registers
    t_state              r_state,  n_state;
    logic [POS_W-1:0]    r_pos,    n_pos;
    logic                r_ovf,    n_ovf;
    logic [POS_W-1:0]    r_sb;
    t_cmd                r_cmd,    n_cmd;
    logic [COUNT_W-1:0]  r_n,      n_n;
    logic [BADDR_W-1:0]  r_addr,   n_addr;
    logic [FETCH_W-1:0]  r_issue,  n_issue;
    logic [FETCH_W-1:0]  r_recv,   n_recv;
    logic [ACC_W-1:0]    r_acc,    n_acc;
    logic [ITER_W-1:0]   r_iter,   n_iter;
    logic [VAR_W-1:0]    r_vres,   n_vres;
    logic [VALUE_W-1:0]  r_value,  n_value;

    // datapath terms
    t_cmd                in_cmd;
    logic [COUNT_W-1:0]  cnt_raw;
    logic [COUNT_W-1:0]  cnt;
    logic [POSX_W-1:0]   sb_x;
    logic [BADDR_W-1:0]  stream_end_addr;
    logic [POSX_W-1:0]   adv_sum;
    logic [POSX_W-1:0]   rd_sum;
    logic [POSX_W-1:0]   var_sum;
    logic [2:0]          off;
    logic [ACC_W-1:0]    shifted;
    logic [VALUE_W-1:0]  mask;
    logic [VALUE_W-1:0]  masked;
    logic                sbit;
    logic [BYTE_W-1:0]   vbyte;
    logic [5:0]          vshift;
    logic [VAR_W-1:0]    vres_next;
    logic                bit_val;

    // stream length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb <= '0;
        end else if (i_cfg_we) begin
            r_sb <= i_cfg_wdata;
        end
    end

    // shared arithmetic
    always_comb begin
        in_cmd   = t_cmd'(i_cmd.payload.command);
        cnt_raw  = i_cmd.payload.count;
        cnt      = (cnt_raw > COUNT_W'(MAX_READ)) ? COUNT_W'(MAX_READ) : cnt_raw;
        sb_x     = POSX_W'(r_sb);
        stream_end_addr = BADDR_W'((sb_x + POSX_W'(7)) >> 3);
        adv_sum  = POSX_W'(r_pos) + POSX_W'(cnt_raw);
        rd_sum   = POSX_W'(r_pos) + POSX_W'(r_n);
        var_sum  = POSX_W'(r_pos) + POSX_W'(BYTE_W);
        off      = r_pos[2:0];
        // multi-bit read: window aligned to the start bit, cut to the count
        shifted  = r_acc >> off;
        mask     = r_n[6] ? '1 : ((VALUE_W'(1) << r_n[5:0]) - VALUE_W'(1));
        masked   = shifted[VALUE_W-1:0] & mask;
        sbit     = masked[6'(r_n - COUNT_W'(1))];
        // varuint: eight bits from the two newest bytes
        vbyte    = BYTE_W'(r_acc[ACC_W-1 -: 2*BYTE_W] >> off);
        vshift   = 6'(r_iter) * 6'd7;
        vres_next = r_vres | (VAR_W'(vbyte[6:0]) << vshift);
        // single bit from the newest byte
        bit_val  = r_acc[ACC_W-BYTE_W + 32'(off)];
    end

    // next state and outputs
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_ovf   = r_ovf;
        n_cmd   = r_cmd;
        n_n     = r_n;
        n_addr  = r_addr;
        n_issue = r_issue;
        n_recv  = r_recv;
        n_acc   = r_acc;
        n_iter  = r_iter;
        n_vres  = r_vres;
        n_value = r_value;
        o_wr    = '0;
        o_rd    = '0;
        o_valid = 1'b0;
        i_cmd.ready = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd   = in_cmd;
                    n_n     = cnt;
                    n_value = '0;
                    n_addr  = BADDR_W'(r_pos >> 3);
                    n_state = S_DONE;
                    unique case (in_cmd)
                        CMD_LOAD: begin
                            o_wr.we   = 1'b1;
                            o_wr.addr = i_cmd.payload.byte_index;
                            o_wr.data = i_cmd.payload.byte_value;
                        end
                        CMD_REWIND: begin
                            n_pos = '0;
                            n_ovf = 1'b0;
                        end
                        CMD_READ_U, CMD_READ_S: begin
                            if (cnt != '0 && !r_ovf) begin
                                n_issue = FETCH_W'(READ_BYTES);
                                n_recv  = FETCH_W'(READ_BYTES);
                                n_state = S_FETCH;
                            end
                        end
                        CMD_ADVANCE: begin
                            if (adv_sum > sb_x) begin
                                n_pos = r_sb;
                                n_ovf = 1'b1;
                            end else begin
                                n_pos = adv_sum[POS_W-1:0];
                            end
                        end
                        CMD_READ_BIT: begin
                            if (r_ovf || r_pos >= r_sb) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_issue = FETCH_W'(1);
                                n_recv  = FETCH_W'(1);
                                n_state = S_FETCH;
                            end
                        end
                        CMD_READ_VAR: begin
                            if (!r_ovf) begin
                                n_issue = FETCH_W'(2);
                                n_recv  = FETCH_W'(2);
                                n_iter  = '0;
                                n_vres  = '0;
                                n_state = S_FETCH;
                            end
                        end
                        CMD_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // issue byte reads, shift returning bytes in from the top
            S_FETCH: begin
                if (r_issue != '0) begin
                    o_rd.re    = 1'b1;
                    o_rd.addr  = r_addr;
                    o_rd.blank = !(r_addr < stream_end_addr);
                    n_addr     = r_addr + BADDR_W'(1);
                    n_issue    = r_issue - FETCH_W'(1);
                end
                if (i_rd.valid) begin
                    n_acc  = {i_rd.data, r_acc[ACC_W-1:BYTE_W]};
                    n_recv = r_recv - FETCH_W'(1);
                    if (r_recv == FETCH_W'(1)) begin
                        n_state = (r_cmd == CMD_READ_VAR) ? S_VAR : S_CALC;
                    end
                end
            end

            // one varuint group: advance, clamp, continue on the high bit unless clamped or at the last group
            S_VAR: begin
                n_vres = vres_next;
                if (var_sum > sb_x) begin
                    n_pos = r_sb;
                    n_ovf = 1'b1;
                end else begin
                    n_pos = var_sum[POS_W-1:0];
                end
                if (vbyte[7] && !(var_sum > sb_x) &&
                    r_iter != ITER_W'(VAR_GROUPS - 1)) begin
                    n_iter  = r_iter + ITER_W'(1);
                    n_issue = FETCH_W'(1);
                    n_recv  = FETCH_W'(1);
                    n_state = S_FETCH;
                end else begin
                    // varuint32: bits of the last group above bit 31 drop out
                    n_value = VALUE_W'(vres_next[31:0]);
                    n_state = S_DONE;
                end
            end

            // final value and position of a bit or multi-bit read
            S_CALC: begin
                if (r_cmd == CMD_READ_BIT) begin
                    n_value = VALUE_W'(bit_val);
                    n_pos   = r_pos + POS_W'(1);
                end else begin
                    n_value = (r_cmd == CMD_READ_S && sbit) ? (masked | ~mask) : masked;
                    if (rd_sum > sb_x) begin
                        n_pos = r_sb;
                        n_ovf = 1'b1;
                    end else begin
                        n_pos = rd_sum[POS_W-1:0];
                    end
                end
                n_state = S_DONE;
            end

            // hand the result word to the output register
            S_DONE: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_ovf   <= 1'b0;
            r_issue <= '0;
            r_recv  <= '0;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_ovf   <= n_ovf;
            r_issue <= n_issue;
            r_recv  <= n_recv;
            r_iter  <= n_iter;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_n     <= n_n;
        r_addr  <= n_addr;
        r_acc   <= n_acc;
        r_vres  <= n_vres;
        r_value <= n_value;
    end

    assign o_word.value    = r_value;
    assign o_word.overflow = r_ovf;
    assign o_word.position = r_pos;

endmodule

`default_nettype wire

FILE: hdl/lsb_bit_field_reader.sv
// lsb_bit_field_reader: top level of the lsb-first bit field reader
// depends on lsbr_pkg, lsbr_if, lsbr_store, lsbr_engine and lsbr_out_reg
//
// Usage: commands arrive as words on i_cmd (valid/ready); each command gives
// exactly one result word on o_res (value, overflow, position). The stream
// length in bits is written through i_cfg_we / i_cfg_wdata while idle.
// Bytes are loaded into the store with load commands before reading.
// Load, rewind, advance, no-op and reads that return zero at once go straight
// to the result; a bit read fetches one byte, a read of 1 to 64 bits nine
// bytes, a varuint32 two bytes and then one for each further byte. One
// command is worked at a time; the store's single read port takes one byte
// read per cycle. A new command is taken the cycle after the previous result
// enters the output register, also while that result still waits on a
// stalled receiver; a second finished result waits in the engine.
// Reset clears position, overflow flag and stream length; the store holds
// no reset value and needs no clearing pass.
`default_nettype none

module lsb_bit_field_reader #(
    parameter int unsigned STORE_BYTES = lsbr_pkg::DEF_STORE_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [13:0] i_cfg_wdata,
    lsbr_if.sink             i_cmd,
    lsbr_if.source           o_res
);
    import lsbr_pkg::*;

    t_wr_req   wr_req;
    t_rd_req   rd_req;
    t_rd_rsp   rd_rsp;
    logic      res_valid;
    logic      res_ready;
    t_res_word res_word;

    // byte store
    lsbr_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr_req),
        .i_rd    (rd_req),
        .o_rd    (rd_rsp)
    );

    // command sequencer
    lsbr_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_cmd),
        .o_wr        (wr_req),
        .o_rd        (rd_req),
        .i_rd        (rd_rsp),
        .o_valid     (res_valid),
        .o_word      (res_word),
        .i_ready     (res_ready)
    );

    // output register
    lsbr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_word  (res_word),
        .o_ready (res_ready),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

FILE: sim/lsbr_result_checker.sv
`timescale 1ns / 100ps
// lsbr_result_checker: predicts every result word of lsb_bit_field_reader and compares it
// depends on lsbr_pkg and lsbr_if; watches the command and result channels, drives only its fail and pending counts

module lsbr_result_checker #(
    parameter int unsigned STORE_BYTES = lsbr_pkg::DEF_STORE_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lsbr_pkg::POS_W-1:0]    i_cfg_wdata,
    lsbr_if                               i_cmd_mon,
    lsbr_if                               i_res_mon,
    output int unsigned                   o_fail_count,
    output int unsigned                   o_pending
);
    import lsbr_pkg::*;

    localparam int unsigned SHOWN_FAILS = 10;

    // mirror of the reader state
    logic [BYTE_W-1:0] mirror_store [STORE_BYTES];
    int unsigned       mirror_pos;
    logic              mirror_ovf;
    int unsigned       mirror_len;

    t_res_word   due_results[$];
    int unsigned fail_total;

    // stream bit, zero at or past the rounded-up end or past the store
    function automatic logic stream_bit(int unsigned pos);
        int unsigned byte_no;
        int unsigned end_no;
        byte_no = pos / BYTE_W;
        end_no  = (mirror_len + BYTE_W - 1) / BYTE_W;
        if (byte_no >= end_no || byte_no >= STORE_BYTES)
            return 1'b0;
        return mirror_store[byte_no][pos % BYTE_W];
    endfunction

    // lsb-first read of n bits, then clamp at the stream end
    function automatic logic [VALUE_W-1:0] take_bits(int unsigned n);
        logic [VALUE_W-1:0] bits;
        bits = '0;
        if (mirror_ovf)
            return '0;
        for (int unsigned i = 0; i < n; i++)
            bits[i] = stream_bit(mirror_pos + i);
        mirror_pos = mirror_pos + n;
        if (mirror_pos > mirror_len) begin
            mirror_pos = mirror_len;
            mirror_ovf = 1'b1;
        end
        return bits;
    endfunction

    // apply one command word to the mirror, return the result word it gives
    function automatic t_res_word reader_result(t_in_word w);
        t_cmd               op;
        int unsigned        n;
        logic [VALUE_W-1:0] val;
        logic [VALUE_W-1:0] grp;
        logic [31:0]        acc;
        logic               more;
        t_res_word          res;
        op  = t_cmd'(w.command);
        val = '0;
        case (op)
            CMD_LOAD: begin
                if (32'(w.byte_index) < STORE_BYTES)
                    mirror_store[w.byte_index] = w.byte_value;
            end
            CMD_REWIND: begin
                mirror_pos = 0;
                mirror_ovf = 1'b0;
            end
            CMD_READ_U, CMD_READ_S: begin
                n = (32'(w.count) > MAX_READ) ? MAX_READ : 32'(w.count);
                if (n != 0) begin
                    val = take_bits(n);
                    // sign extension below the full width
                    if (op == CMD_READ_S && n < MAX_READ && val[n-1])
                        val = val | ({VALUE_W{1'b1}} << n);
                end
            end
            CMD_ADVANCE: begin
                n = 32'(w.count);
                if (mirror_pos > mirror_len || n > mirror_len - mirror_pos) begin
                    mirror_pos = mirror_len;
                    mirror_ovf = 1'b1;
                end else begin
                    mirror_pos = mirror_pos + n;
                end
            end
            CMD_READ_BIT: begin
                if (mirror_ovf || mirror_pos >= mirror_len) begin
                    mirror_ovf = 1'b1;
                end else begin
                    val[0]     = stream_bit(mirror_pos);
                    mirror_pos = mirror_pos + 1;
                end
            end
            CMD_READ_VAR: begin
                acc  = '0;
                more = 1'b1;
                // seven bits per byte, top bit marks a further byte
                for (int unsigned i = 0; i < VAR_GROUPS; i++) begin
                    if (more) begin
                        grp  = take_bits(BYTE_W);
                        acc  = acc | (32'(grp[6:0]) << (7 * i));
                        more = grp[7];
                    end
                end
                val = 64'(acc);
            end
            default: begin
            end
        endcase
        res.value    = val;
        res.overflow = mirror_ovf;
        res.position = POS_W'(mirror_pos);
        return res;
    endfunction

    // predict on accepted commands, compare on accepted results
    always @(posedge i_clk) begin
        t_in_word  cmd_w;
        t_res_word got;
        t_res_word want;
        if (!i_rst_n) begin
            mirror_pos = 0;
            mirror_ovf = 1'b0;
            mirror_len = 0;
            due_results.delete();
        end else begin
            if (i_cfg_we)
                mirror_len = 32'(i_cfg_wdata);
            if (i_cmd_mon.valid && i_cmd_mon.ready) begin
                cmd_w = i_cmd_mon.payload;
                due_results.push_back(reader_result(cmd_w));
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                got = i_res_mon.payload;
                if (due_results.size() == 0) begin
                    fail_total = fail_total + 1;
                    if (fail_total <= SHOWN_FAILS)
                        $display("%0t: result word with none due: value %h ovf %b pos %0d",
                                 $realtime, got.value, got.overflow, got.position);
                end else begin
                    want = due_results.pop_front();
                    if (got.value !== want.value || got.overflow !== want.overflow ||
                        got.position !== want.position) begin
                        fail_total = fail_total + 1;
                        if (fail_total <= SHOWN_FAILS) begin
                            $display("%0t: mismatch, expected value %h ovf %b pos %0d",
                                     $realtime, want.value, want.overflow, want.position);
                            $display("%0t:             actual value %h ovf %b pos %0d",
                                     $realtime, got.value, got.overflow, got.position);
                        end
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= due_results.size();
    end

endmodule

FILE: sim/lsb_bit_field_reader_test.sv
`timescale 1ns / 100ps
// lsb_bit_field_reader_test: stimulus, stream length phases and verdict for the bit reader
// depends on lsbr_pkg, lsbr_if, lsb_bit_field_reader and lsbr_result_checker

module lsb_bit_field_reader_test;
    import lsbr_pkg::*;

    localparam int unsigned STORE_BYTES = DEF_STORE_BYTES;
    // loaded head of the store; streams never reach past it
    localparam int unsigned FILL_BYTES  = 135;
    localparam int unsigned FULL_LEN    = FILL_BYTES * BYTE_W;
    localparam int unsigned RAND_PHASES = 12;
    localparam int unsigned PHASE_ITEMS = 36;
    localparam int unsigned IDLE_PCT    = 18;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SEEK_STEP   = 127;
    localparam int unsigned SEEK_STEPS  = 8;
    localparam int unsigned FAR_STEPS   = 6;
    localparam int unsigned SHRINK_MAX  = 700;
    localparam int unsigned TAIL_CYCLES = 20;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [POS_W-1:0]  i_cfg_wdata;
    logic              gaps_on = 1'b1;
    logic              hold_req = 1'b0;
    int unsigned       fail_count;
    int unsigned       pending;

    // bytes at the head of the stream, chosen for long varuint chains
    logic [BYTE_W-1:0] head_bytes [8] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h01};

    lsbr_if #(.t_word(t_in_word))  cmd_bus ();
    lsbr_if #(.t_word(t_res_word)) res_bus ();

    lsb_bit_field_reader #(
        .STORE_BYTES (STORE_BYTES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_bus),
        .o_res       (res_bus)
    );

    lsbr_result_checker #(
        .STORE_BYTES (STORE_BYTES)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd_mon    (cmd_bus),
        .i_res_mon    (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hard stop
    initial begin
        #2000000;
        $display("lsb_bit_field_reader_test failed");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        res_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                res_bus.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
                @(posedge i_clk);
            end
        end
    end

    function automatic t_in_word make_cmd(t_cmd op, int unsigned cnt, int unsigned idx,
                                          int unsigned val);
        t_in_word w;
        w.command    = op;
        w.count      = COUNT_W'(cnt);
        w.byte_index = IDX_W'(idx);
        w.byte_value = BYTE_W'(val);
        return w;
    endfunction

    // weighted command mix with random fields
    function automatic t_in_word random_cmd();
        int unsigned pick;
        int unsigned cnt;
        t_cmd        op;
        pick = $urandom_range(99);
        if (pick < 8)       op = CMD_REWIND;
        else if (pick < 14) op = CMD_LOAD;
        else if (pick < 40) op = CMD_READ_U;
        else if (pick < 56) op = CMD_READ_S;
        else if (pick < 68) op = CMD_ADVANCE;
        else if (pick < 80) op = CMD_READ_BIT;
        else if (pick < 95) op = CMD_READ_VAR;
        else                op = CMD_NOP;
        cnt = ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(64, 1);
        return make_cmd(op, cnt, $urandom_range(STORE_BYTES - 1), $urandom_range(255));
    endfunction

    // offer one command word until accepted
    task automatic issue_command(input t_in_word w);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.payload <= w;
        do @(posedge i_clk); while (!cmd_bus.ready);
    endtask

    // stop offering and wait until every due result word has arrived
    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_stream_bits(input int unsigned len);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= POS_W'(len);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int unsigned len;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        cmd_bus.valid   <= 1'b0;
        cmd_bus.payload <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty stream: every read overruns, store never written
        set_stream_bits(0);
        issue_command(make_cmd(CMD_READ_U, 64, 0, 0));
        issue_command(make_cmd(CMD_READ_BIT, 1, 0, 0));
        issue_command(make_cmd(CMD_REWIND, 0, 0, 0));
        issue_command(make_cmd(CMD_ADVANCE, 0, 0, 0));
        issue_command(make_cmd(CMD_READ_VAR, 0, 0, 0));
        issue_command(make_cmd(CMD_NOP, 127, 1023, 255));
        issue_command(make_cmd(CMD_READ_S, 0, 0, 0));

        // fill the head of the store; no stream reaches past it
        for (int unsigned i = 0; i < FILL_BYTES; i++)
            issue_command(make_cmd(CMD_LOAD, $urandom_range(127), i,
                                   (i < 8) ? 32'(head_bytes[i]) : $urandom_range(255)));
        drain_results();

        // full-length stream: varuint chains, sign extension, count limits
        set_stream_bits(FULL_LEN);
        issue_command(make_cmd(CMD_READ_VAR, 0, 0, 0));
        issue_command(make_cmd(CMD_READ_VAR, 0, 0, 0));
        issue_command(make_cmd(CMD_REWIND, 0, 0, 0));
        issue_command(make_cmd(CMD_READ_S, 1, 0, 0));
        issue_command(make_cmd(CMD_READ_S, 64, 0, 0));
        issue_command(make_cmd(CMD_READ_U, 127, 0, 0));
        issue_command(make_cmd(CMD_READ_BIT, 0, 0, 0));
        issue_command(make_cmd(CMD_ADVANCE, 127, 0, 0));
        issue_command(make_cmd(CMD_READ_S, 7, 0, 0));
        issue_command(make_cmd(CMD_READ_U, 0, 0, 0));
        issue_command(make_cmd(CMD_NOP, 0, 0, 0));

        // random phases, each with its own stream length
        for (int unsigned p = 0; p < RAND_PHASES; p++) begin
            drain_results();
            case (p)
                0, 4, 5: len = FULL_LEN;
                1:       len = 0;
                default: begin
                    case ($urandom_range(3))
                        0:       len = $urandom_range(96, 1);
                        1:       len = $urandom_range(FULL_LEN);
                        2:       len = BYTE_W * $urandom_range(16, 1);
                        default: len = $urandom_range(FULL_LEN, FULL_LEN - 92);
                    endcase
                end
            endcase
            set_stream_bits(len);
            gaps_on = !(p == 2 || p == 8);
            if (p == 4) begin
                // seek to the last 64 bits of the full stream
                issue_command(make_cmd(CMD_REWIND, 0, 0, 0));
                for (int unsigned s = 0; s < SEEK_STEPS; s++)
                    issue_command(make_cmd(CMD_ADVANCE, SEEK_STEP, s, s));
            end else if (p == 5) begin
                // move far in, then shrink the stream below the position
                issue_command(make_cmd(CMD_REWIND, 0, 0, 0));
                for (int unsigned s = 0; s < FAR_STEPS; s++)
                    issue_command(make_cmd(CMD_ADVANCE, SEEK_STEP, s, s));
                drain_results();
                set_stream_bits($urandom_range(SHRINK_MAX));
            end else if ($urandom_range(1) == 1) begin
                issue_command(make_cmd(CMD_REWIND, 0, 0, 0));
            end
            for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 6 && k == 10)
                    hold_req = 1'b1;
                issue_command(random_cmd());
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("lsb_bit_field_reader_test passed");
        else
            $display("lsb_bit_field_reader_test failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/lsbr_pkg.sv
hdl/lsbr_if.sv
hdl/lsbr_store.sv
hdl/lsbr_out_reg.sv
hdl/lsbr_engine.sv
hdl/lsb_bit_field_reader.sv
sim/lsbr_result_checker.sv
sim/lsb_bit_field_reader_test.sv
